/* src/lwma_pkg.sv */
package lwma_pkg;

    localparam int LwmaWindow   = 64;
    localparam int WideW        = 256;
    localparam logic [16:0] SpacingReset = 17'd120;
    localparam logic [31:0] LimitReset   = 32'd504365055;

    localparam logic CfgSpacing = 1'b0;
    localparam logic CfgLimit   = 1'b1;

    typedef logic [WideW-1:0] t_wide;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_K10S, S_K10W, S_WAITA, S_SEED, S_WAITB, S_STEP, S_MAC,
        S_AVGS, S_AVGW, S_FLOOR, S_MUL, S_KDS, S_KDW, S_CHECK, S_ENCL, S_ENCW, S_OUT
    } t_state;

    // compact word -> 256-bit target; sign bit ignored, overflow reads as zero
    function automatic t_wide lwma_decode(input logic [31:0] bits);
        logic [7:0] sz;
        logic [8:0] sh;
        t_wide      w;
        t_wide      r;
        sz = bits[31:24];
        w  = {233'd0, bits[22:0]};
        sh = '0;
        if (sz <= 8'd3) begin
            sh = {1'b0, 8'd3 - sz} << 3;
            r  = w >> sh;
        end else if (sz >= 8'd35) begin
            r = '0;
        end else begin
            sh = {1'b0, sz - 8'd3} << 3;
            r  = w << sh;
        end
        return r;
    endfunction

endpackage

/* src/lwma_div.sv */
module lwma_div
    import lwma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_wide       i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output t_wide       o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [7:0]  r_cnt, n_cnt;
    t_wide       r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_d, n_d;
    logic [32:0] rem2;
    logic [32:0] diff;
    logic        ge;

    // restoring divide, one quotient bit a cycle, MSB first
    always_comb begin
        rem2 = {r_rem, r_q[WideW-1]};
        ge   = rem2 >= {1'b0, r_d};
        diff = rem2 - {1'b0, r_d};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[31:0] : rem2[31:0];
            n_q   = {r_q[WideW-2:0], ge};
            n_cnt = r_cnt + 8'd1;
            if (r_cnt == 8'd255) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* src/lwma_enc.sv */
module lwma_enc
    import lwma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_wide       i_value,
    output logic        o_done,
    output logic [31:0] o_code
);

    logic        r_busy;
    logic        r_done;
    t_wide       r_x;
    logic [4:0]  r_b;
    logic [31:0] r_code;
    logic        big;
    logic [4:0]  nbits;
    logic [5:0]  size;
    logic [4:0]  sh;
    logic [23:0] mant;
    logic [31:0] code;

    assign big = |r_x[WideW-1:24];

    // byte-serial normalize: shift right until the value fits in 24 bits
    always_comb begin
        nbits = '0;
        for (int j = 0; j < 24; j++) begin
            if (r_x[j]) nbits = 5'(j + 1);
        end
        sh = '0;
        if (r_b == '0) begin
            size = 6'((nbits + 5'd7) >> 3);
            sh   = 5'((6'd3 - size) << 3);
            mant = r_x[23:0] << sh;
        end else begin
            size = 6'(r_b) + 6'd3;
            mant = r_x[23:0];
        end
        if (mant[23]) begin
            mant = mant >> 8;
            size = size + 6'd1;
        end
        code = {2'b00, size, mant};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !big) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x <= i_value;
            r_b <= '0;
        end else if (r_busy) begin
            if (big) begin
                r_x <= r_x >> 8;
                r_b <= r_b + 5'd1;
            end else begin
                r_code <= code;
            end
        end
    end

    assign o_done = r_done;
    assign o_code = r_code;

endmodule

/* src/lwma_difficulty_retarget.sv */
// Once the window is full, each block runs a weighted pass over the window;
// during warm-up the configured limit is encoded directly.
// Each window step is set by the bit-serial divider, plus a 32-bit limb
// multiply-accumulate. One block is in flight at a time.
// Synchronous active-low reset clears control, config and block count;
// window memories are not cleared (never read before written).
module lwma_difficulty_retarget
    import lwma_pkg::*;
#(
    parameter int WINDOW = LwmaWindow
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] block_time, [63:32] block_bits
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] next_bits
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int TDEPTH = WINDOW + 1;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int BA_W   = $clog2(WINDOW);
    localparam int SEEN_W = $clog2(WINDOW + 2);
    localparam int STEP_W = $clog2(WINDOW + 1);
    localparam int KC     = WINDOW * (WINDOW + 1) / 2;
    localparam logic [7:0] WM1 = 8'(WINDOW - 1);

    t_state r_state, n_state;

    logic [16:0]       r_ts;
    logic [31:0]       r_lc;
    logic [31:0]       r_tmem [TDEPTH];
    logic [31:0]       r_bmem [WINDOW];
    logic [TA_W-1:0]   r_twa, r_tnew, r_tra;
    logic [BA_W-1:0]   r_bwa, r_bnew, r_bra;
    logic [31:0]       r_tq, r_bq;
    logic [SEEN_W-1:0] r_seen;
    logic [STEP_W-1:0] r_step;
    logic [2:0]        r_limb;
    logic [31:0]       r_k, r_k10, r_tcur;
    logic [19:0]       r_cap;
    t_wide             r_lim, r_avg, r_tgt;
    logic signed [36:0] r_sum;
    logic [36:0]       r_carry;
    logic              r_ov;
    logic [31:0]       r_od;

    logic        s_acc;
    logic        div_start, div_busy, div_done;
    t_wide       div_dividend, div_quot;
    logic [31:0] div_divisor;
    logic        enc_start, enc_done;
    t_wide       enc_val;
    logic [31:0] enc_code;
    logic        warm, bad, out_go;

    logic signed [32:0] st, st_c;
    logic signed [32:0] cap_s;
    logic [8:0]         weight;
    logic signed [36:0] term;
    logic [40:0]        mac_c;
    logic [68:0]        mul_c;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign warm   = (r_seen < SEEN_W'(WINDOW + 1)) || (r_ts == '0);
    assign bad    = (r_avg == '0) || (r_avg > r_lim);
    assign out_go = !r_ov || i_m_axis_tready;

    // solve time, clamped, weighted; limb multiply-accumulate and multiply terms
    always_comb begin
        cap_s  = $signed({13'd0, r_cap});
        st     = $signed({1'b0, r_tcur}) - $signed({1'b0, r_tq});
        st_c   = st;
        if (st > cap_s) st_c = cap_s;
        if (st < -cap_s) st_c = -cap_s;
        weight = 9'(WINDOW) - 9'(r_step);
        term   = 37'(st_c * $signed({1'b0, weight}));
        mac_c  = 41'(r_avg[31:0] * WM1) + 41'(r_tgt[31:0]) + 41'(r_carry[8:0]);
        mul_c  = 69'(r_avg[31:0] * r_sum[35:0]) + 69'(r_carry);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_acc) n_state = S_PREP;
            S_PREP:  n_state = warm ? S_ENCL : S_K10S;
            S_K10S:  n_state = S_K10W;
            S_K10W:  if (div_done) n_state = S_WAITA;
            S_WAITA: n_state = S_SEED;
            S_SEED:  n_state = S_WAITB;
            S_WAITB: n_state = S_STEP;
            S_STEP:  n_state = S_MAC;
            S_MAC:   if (r_limb == 3'd7) n_state = S_AVGS;
            S_AVGS:  n_state = S_AVGW;
            S_AVGW: begin
                if (div_done) begin
                    n_state = (r_step == STEP_W'(WINDOW - 1)) ? S_FLOOR : S_STEP;
                end
            end
            S_FLOOR: n_state = S_MUL;
            S_MUL:   if (r_limb == 3'd7) n_state = S_KDS;
            S_KDS:   n_state = S_KDW;
            S_KDW:   if (div_done) n_state = S_CHECK;
            S_CHECK: n_state = S_ENCW;
            S_ENCL:  n_state = S_ENCW;
            S_ENCW:  if (enc_done) n_state = S_OUT;
            S_OUT:   if (out_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        div_start    = 1'b0;
        div_dividend = r_avg;
        div_divisor  = 32'(WINDOW);
        enc_start    = 1'b0;
        enc_val      = r_lim;
        case (r_state)
            S_K10S: begin
                div_start    = 1'b1;
                div_dividend = {224'd0, r_k};
                div_divisor  = 32'd10;
            end
            S_AVGS: div_start = 1'b1;
            S_KDS: begin
                div_start   = 1'b1;
                div_divisor = r_k;
            end
            S_CHECK: begin
                enc_start = 1'b1;
                if (!bad) enc_val = r_avg;
            end
            S_ENCL: enc_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_tmem[r_twa] <= i_s_axis_tdata[31:0];
            r_bmem[r_bwa] <= i_s_axis_tdata[63:32];
        end
        r_tq <= r_tmem[r_tra];
        r_bq <= r_bmem[r_bra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ts    <= SpacingReset;
            r_lc    <= LimitReset;
            r_twa   <= '0;
            r_bwa   <= '0;
            r_tnew  <= '0;
            r_bnew  <= '0;
            r_seen  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgSpacing) r_ts <= i_cfg_data[16:0];
                if (i_cfg_idx == CfgLimit)   r_lc <= i_cfg_data;
            end
            if (s_acc) begin
                r_tnew <= r_twa;
                r_bnew <= r_bwa;
                r_twa  <= (r_twa == TA_W'(TDEPTH - 1)) ? '0 : r_twa + 1'b1;
                r_bwa  <= (r_bwa == BA_W'(WINDOW - 1)) ? '0 : r_bwa + 1'b1;
                if (r_seen < SEEN_W'(WINDOW + 1)) r_seen <= r_seen + 1'b1;
            end
            if (r_ov && i_m_axis_tready) r_ov <= 1'b0;
            if (r_state == S_OUT && out_go) r_ov <= 1'b1;
        end

        case (r_state)
            S_PREP: begin
                r_k   <= 32'(r_ts) * 32'(KC);
                r_cap <= 20'(r_ts) * 20'd6;
                r_lim <= lwma_decode(r_lc);
            end
            S_K10W: begin
                r_k10 <= div_quot[31:0];
                r_tra <= r_tnew;
                r_bra <= r_bnew;
            end
            S_SEED: begin
                r_tcur <= r_tq;
                r_avg  <= lwma_decode(r_bq);
                r_tra  <= (r_tra == '0) ? TA_W'(TDEPTH - 1) : r_tra - 1'b1;
                r_step <= '0;
                r_sum  <= '0;
            end
            S_STEP: begin
                r_sum   <= r_sum + term;
                r_tcur  <= r_tq;
                r_tgt   <= lwma_decode(r_bq);
                r_tra   <= (r_tra == '0) ? TA_W'(TDEPTH - 1) : r_tra - 1'b1;
                r_bra   <= (r_bra == '0) ? BA_W'(WINDOW - 1) : r_bra - 1'b1;
                r_limb  <= '0;
                r_carry <= '0;
            end
            S_MAC: begin
                r_avg   <= {mac_c[31:0], r_avg[WideW-1:32]};
                r_tgt   <= r_tgt >> 32;
                r_carry <= {28'd0, mac_c[40:32]};
                r_limb  <= r_limb + 3'd1;
            end
            S_AVGW: begin
                if (div_done) begin
                    r_avg  <= div_quot;
                    r_step <= r_step + 1'b1;
                end
            end
            S_FLOOR: begin
                if (r_sum < $signed({5'd0, r_k10})) r_sum <= $signed({5'd0, r_k10});
                r_limb  <= '0;
                r_carry <= '0;
            end
            S_MUL: begin
                r_avg   <= {mul_c[31:0], r_avg[WideW-1:32]};
                r_carry <= mul_c[68:32];
                r_limb  <= r_limb + 3'd1;
            end
            S_KDW: if (div_done) r_avg <= div_quot;
            S_OUT: if (out_go) r_od <= enc_code;
            default: ;
        endcase
    end

    lwma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    lwma_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (enc_start),
        .i_value (enc_val),
        .o_done  (enc_done),
        .o_code  (enc_code)
    );

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

    a_acc_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_PREP)
        else $error("accepted beat did not start processing");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(WINDOW + 1))
        else $error("block count past saturation");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_go) |=> r_state == S_OUT && r_ov)
        else $error("result lost while output stalled");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lwma_pkg::*;

    localparam int          WIN        = LwmaWindow;
    localparam longint      CYCLE_CAP  = 64'd60_000_000;
    localparam logic [31:0] RESET_ANS  = 32'h1E0F_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    lwma_difficulty_retarget dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // model state of the retarget block
    logic [16:0] spacing_m;
    logic [31:0] limit_m;
    logic [31:0] time_hist [0:WIN];
    logic [31:0] bits_hist [0:WIN-1];
    int          seen_m;

    logic [31:0] next_bits_q [$];
    int          fail_cnt;
    int          results_seen;
    longint      cycle_cnt;

    typedef struct {
        logic [31:0] btime;
        logic [31:0] bbits;
        logic        typed;
        logic [31:0] answer;
    } t_row;

    function automatic t_wide unpack_target(input logic [31:0] c);
        t_wide w;
        int    ex;
        ex = c[31:24];
        w  = {233'd0, c[22:0]};
        if (ex <= 3) return w >> (8 * (3 - ex));
        if (ex >= 35) return '0;
        return w << (8 * (ex - 3));
    endfunction

    function automatic logic [31:0] pack_target(input t_wide x);
        int          nb;
        int          sz;
        logic [31:0] c;
        t_wide       t;
        nb = 0;
        for (int b = 255; b >= 0; b--) begin
            if (x[b]) begin
                nb = b + 1;
                break;
            end
        end
        sz = (nb + 7) / 8;
        if (sz <= 3) begin
            c = x[31:0] << (8 * (3 - sz));
        end else begin
            t = x >> (8 * (sz - 3));
            c = t[31:0];
        end
        if (c[23]) begin
            c = c >> 8;
            sz++;
        end
        return {sz[7:0], c[23:0]};
    endfunction

    function automatic logic [31:0] retarget(input logic [31:0] bt, input logic [31:0] bb);
        t_wide  lim;
        t_wide  avg;
        t_wide  nxt;
        longint k;
        longint cap;
        longint acc;
        longint st;
        lim = unpack_target(limit_m);
        for (int i = WIN; i > 0; i--) time_hist[i] = time_hist[i-1];
        for (int i = WIN - 1; i > 0; i--) bits_hist[i] = bits_hist[i-1];
        time_hist[0] = bt;
        bits_hist[0] = bb;
        if (seen_m < WIN + 1) seen_m++;
        k = longint'(spacing_m) * WIN * (WIN + 1) / 2;
        if (seen_m < WIN + 1 || k == 0) return pack_target(lim);
        cap = 6 * longint'(spacing_m);
        acc = 0;
        avg = unpack_target(bits_hist[0]);
        for (int i = 0; i < WIN; i++) begin
            st = longint'(time_hist[i]) - longint'(time_hist[i+1]);
            if (st > cap) st = cap;
            if (st < -cap) st = -cap;
            acc += st * (WIN - i);
            avg = avg * 256'(WIN - 1);
            avg = avg + unpack_target(bits_hist[i]);
            avg = avg / 256'(WIN);
        end
        if (acc < k / 10) acc = k / 10;
        nxt = avg * {192'd0, acc[63:0]};
        nxt = nxt / 256'(k);
        if (nxt == '0 || nxt > lim) return pack_target(lim);
        return pack_target(nxt);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("lwma_difficulty_retarget verification failed");
            $finish;
        end
    end

    // result side: check and randomized backpressure, with one long hold-off
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (next_bits_q.size() == 0) begin
                $error("unexpected beat next_bits=%h", o_m_axis_tdata);
                fail_cnt++;
            end else begin
                if (o_m_axis_tdata !== next_bits_q[0]) begin
                    $error("next_bits expected %h actual %h", next_bits_q[0], o_m_axis_tdata);
                    fail_cnt++;
                end
                void'(next_bits_q.pop_front());
            end
        end
        if (!hold_done && results_seen == 30) begin
            hold_done = 1;
            hold_left = 40000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (results_seen < 10 || results_seen % 97 > 80) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= (pick_gap() == 0);
        end
    end

    task automatic send_block(input logic [31:0] bt, input logic [31:0] bb,
                              input logic typed, input logic [31:0] answer);
        logic [31:0] pred;
        int          gap;
        i_s_axis_tdata  <= {bb, bt};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = retarget(bt, bb);
        next_bits_q.push_back(typed ? answer : pred);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (next_bits_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CfgSpacing) spacing_m = val[16:0];
        else limit_m = val;
    endtask

    task automatic random_blocks(input int count);
        logic [31:0] t_prev;
        logic [31:0] bt;
        logic [31:0] bb;
        int          tsp;
        int          r;
        t_prev = time_hist[0];
        tsp = (spacing_m == 0) ? 120 : spacing_m;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                bt = t_prev + tsp + $urandom_range(0, 2 * tsp) - tsp;
                bb = {8'($urandom_range(8'h19, 8'h1e)), 1'($urandom_range(0, 9) == 0),
                      23'($urandom)};
            end else if (r < 88) begin
                bt = ($urandom_range(0, 1)) ? t_prev + 20 * tsp : t_prev - 10 * tsp;
                bb = {8'($urandom_range(0, 40)), 24'($urandom)};
            end else begin
                bt = $urandom;
                bb = $urandom;
            end
            t_prev = bt;
            send_block(bt, bb, 1'b0, '0);
        end
    endtask

    t_row rows [$];

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CfgSpacing;
        i_cfg_data      = '0;
        fail_cnt        = 0;
        results_seen    = 0;
        cycle_cnt       = 0;
        hold_left       = 0;
        hold_done       = 0;
        spacing_m       = SpacingReset;
        limit_m         = LimitReset;
        seen_m          = 0;

        // warm-up beats: answer is always the re-encoded reset limit
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b1, RESET_ANS});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_0000, 32'h1D00_FFFF, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_0078, 32'h0380_0000, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_00F0, 32'h0012_3456, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_0168, 32'h0112_3456, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_01E0, 32'h0212_3456, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_0258, 32'h2300_0001, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_02D0, 32'h227F_FFFF, 1'b1, RESET_ANS});
        rows.push_back('{32'h8000_0000, 32'h1E8F_FFFF, 1'b1, RESET_ANS});
        rows.push_back('{32'h7FFF_FFFF, 32'hFF7F_FFFF, 1'b1, RESET_ANS});
        rows.push_back('{32'h0000_1000, 32'h1B0F_FFFF, 1'b1, RESET_ANS});
        for (int i = 0; i < 13; i++)
            rows.push_back('{32'h0000_2000 + 120 * i, 32'h1D00_FFFF - i, 1'b1, RESET_ANS});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_m_axis_tready <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_block(rows[i].btime, rows[i].bbits, rows[i].typed,
                                     rows[i].answer);
        random_blocks(70);

        write_reg(CfgSpacing, 32'd1);
        write_reg(CfgLimit, 32'hFFFF_FFFF);
        random_blocks(97);
        write_reg(CfgSpacing, 32'd86400);
        write_reg(CfgLimit, 32'h1D00_FFFF);
        random_blocks(97);
        write_reg(CfgSpacing, 32'd0);
        write_reg(CfgLimit, 32'h0000_0000);
        random_blocks(97);
        write_reg(CfgSpacing, 32'($urandom_range(2, 600)));
        write_reg(CfgLimit, {8'($urandom_range(1, 34)), 24'($urandom)});
        random_blocks(97);
        write_reg(CfgSpacing, 32'd120);
        write_reg(CfgLimit, LimitReset);
        random_blocks(97);

        i_s_axis_tvalid <= 1'b0;
        while (next_bits_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("lwma_difficulty_retarget verification clean");
        end else begin
            $display("lwma_difficulty_retarget verification failed");
        end
        $finish;
    end

endmodule
